FILE: hdl/cbq_pkg.sv
// Shared types, widths and arithmetic helpers for the cascaded biquad filter core.
// Used by cbq_cell, cbq_gain and cascaded_biquad_iir_filter_core; no dependencies.
`default_nettype none

package cbq_pkg;

    localparam int SECTIONS_DEF = 8;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 24;
    localparam int DATA_W       = 32;
    localparam int PROD_W       = 56;
    localparam int ACC_W        = 58;
    localparam int RND_SH       = 20;
    localparam int CIDX_W       = 8;
    localparam int NSEC_W       = 5;
    localparam int SUSED_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int COEFS_PER_SECT = 5;

    // Coefficient slots inside one section.
    localparam int K_A1 = 0;
    localparam int K_A2 = 1;
    localparam int K_B0 = 2;
    localparam int K_B1 = 3;
    localparam int K_B2 = 4;

    localparam logic signed [COEF_W-1:0] GAIN_RESET    = 24'sd1048576;
    localparam logic [SUSED_W-1:0]       SECTIONS_RESET = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN     = 2'd0,
        REG_SECTIONS = 2'd1
    } t_reg_idx;

    // Sample moving along the chain of sections.
    typedef struct packed {
        logic                     vld;
        logic                     sat;
        logic signed [DATA_W-1:0] val;
    } t_tok;

    // Coefficient write broadcast to every section.
    typedef struct packed {
        logic                     vld;
        logic [CIDX_W-1:0]        idx;
        logic signed [COEF_W-1:0] val;
    } t_cw;

    typedef struct packed {
        logic                       vld;
        logic                       sat;
        logic signed [SAMPLE_W-1:0] val;
    } t_res;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] val;
    } t_rs32;

    // Round half up at bit RND_SH, floor shift, then saturate to DATA_W bits.
    function automatic t_rs32 rnd_sat32(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0]        t;
        logic signed [ACC_W-RND_SH-1:0] q;
        t_rs32                          r;
        t = a + (ACC_W'(1) <<< (RND_SH - 1));
        q = t[ACC_W-1:RND_SH];
        if ((&q[ACC_W-RND_SH-1:DATA_W-1]) || !(|q[ACC_W-RND_SH-1:DATA_W-1])) begin
            r.sat = 1'b0;
            r.val = q[DATA_W-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = q[ACC_W-RND_SH-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cbq_cell.sv
// One direct form II biquad section: its coefficients, its two delays and a
// three-step datapath. Depends on cbq_pkg.
`default_nettype none

module cbq_cell
    import cbq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [CIDX_W-1:0] i_base,
    input  wire t_tok              i_tok,
    input  wire t_cw               i_cw,
    output t_tok                   o_tok
);

    logic signed [COEF_W-1:0] r_c [COEFS_PER_SECT];
    logic signed [DATA_W-1:0] r_w1;
    logic signed [DATA_W-1:0] r_w2;

    // Products of the delays are recomputed every cycle and registered, then summed
    // into r_pa and r_pb, so a delay or coefficient change reaches both sum registers.
    logic signed [PROD_W-1:0] r_ma1;
    logic signed [PROD_W-1:0] r_ma2;
    logic signed [PROD_W-1:0] r_mb1;
    logic signed [PROD_W-1:0] r_mb2;
    logic signed [ACC_W-1:0]  r_pa;
    logic signed [ACC_W-1:0]  r_pb;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_ov;
    logic signed [DATA_W-1:0] r_wn;
    logic                     r_sat1;
    logic signed [PROD_W-1:0] r_m5;
    logic                     r_sat2;
    logic signed [DATA_W-1:0] r_y;
    logic                     r_ysat;

    logic                     tok_v;
    t_rs32                    w_rs;
    t_rs32                    y_rs;

    assign tok_v = i_tok.vld & i_en;
    assign w_rs  = rnd_sat32((ACC_W'($signed(i_tok.val)) <<< RND_SH) - r_pa);
    assign y_rs  = rnd_sat32(ACC_W'(r_m5) + r_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEFS_PER_SECT; k++) begin
                r_c[k] <= '0;
            end
            r_w1 <= '0;
            r_w2 <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= tok_v;
            r_v2 <= r_v1;
            r_ov <= r_v2;
            for (int k = 0; k < COEFS_PER_SECT; k++) begin
                if (i_cw.vld && (i_cw.idx == i_base + CIDX_W'(k))) begin
                    r_c[k] <= i_cw.val;
                end
            end
            if (r_v2) begin
                r_w1 <= r_wn;
                r_w2 <= r_w1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma1 <= PROD_W'(r_c[K_A1]) * PROD_W'(r_w1);
        r_ma2 <= PROD_W'(r_c[K_A2]) * PROD_W'(r_w2);
        r_mb1 <= PROD_W'(r_c[K_B1]) * PROD_W'(r_w1);
        r_mb2 <= PROD_W'(r_c[K_B2]) * PROD_W'(r_w2);
        r_pa  <= ACC_W'(r_ma1) + ACC_W'(r_ma2);
        r_pb  <= ACC_W'(r_mb1) + ACC_W'(r_mb2);
        if (tok_v) begin
            r_wn   <= w_rs.val;
            r_sat1 <= i_tok.sat | w_rs.sat;
        end
        if (r_v1) begin
            r_m5   <= PROD_W'(r_c[K_B0]) * PROD_W'(r_wn);
            r_sat2 <= r_sat1;
        end
        if (r_v2) begin
            r_y    <= y_rs.val;
            r_ysat <= r_sat2 | y_rs.sat;
        end
    end

    assign o_tok.vld = r_ov;
    assign o_tok.sat = r_ysat;
    assign o_tok.val = r_y;

endmodule

`default_nettype wire

FILE: hdl/cbq_gain.sv
// Output stage: multiplies the last section's output by the overall gain,
// rounds and saturates to a 16-bit sample. Depends on cbq_pkg.
`default_nettype none

module cbq_gain
    import cbq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_tok                     i_tok,
    input  wire logic signed [COEF_W-1:0] i_gain,
    output t_res                          o_res
);

    localparam int Q_W = PROD_W - RND_SH;

    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_psat;
    logic                       r_pv;
    logic                       r_ov;
    logic                       r_osat;
    logic signed [SAMPLE_W-1:0] r_oval;

    logic signed [PROD_W-1:0]   rnd;
    logic signed [Q_W-1:0]      q;
    logic                       q_ovf;
    logic signed [SAMPLE_W-1:0] q_sat;

    always_comb begin
        rnd   = r_prod + (PROD_W'(1) <<< (RND_SH - 1));
        q     = rnd[PROD_W-1:RND_SH];
        q_ovf = !((&q[Q_W-1:SAMPLE_W-1]) || !(|q[Q_W-1:SAMPLE_W-1]));
        if (q_ovf) begin
            q_sat = q[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                             : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            q_sat = q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= i_tok.vld;
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_prod <= PROD_W'($signed(i_tok.val)) * PROD_W'(i_gain);
            r_psat <= i_tok.sat;
        end
        if (r_pv) begin
            r_oval <= q_sat;
            r_osat <= r_psat | q_ovf;
        end
    end

    assign o_res.vld = r_ov;
    assign o_res.sat = r_osat;
    assign o_res.val = r_oval;

endmodule

`default_nettype wire

FILE: hdl/cascaded_biquad_iir_filter_core.sv
// Cascaded biquad IIR filter core: a chain of biquad section cells and a gain stage.
// A sample passes from the input register through the section cells in use and the gain
// stage to the output register; each section cell has three steps (feedback sum, b0
// product, output sum). No new sample or coefficient write is taken until the previous
// one is through, and a write passes through a settle state. Reset is synchronous and
// active low; it clears the coefficients, the delays and the control state and enters settle.
`default_nettype none

module cascaded_biquad_iir_filter_core
    import cbq_pkg::*;
#(
    parameter int SECTIONS = SECTIONS_DEF
)
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_mode,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_in,
    input  wire logic [5:0]                 i_coef_index,
    input  wire logic signed [COEF_W-1:0]   i_coef_value,

    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0]      o_sample_out,
    output logic                            o_saturated,

    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [COEF_W-1:0]          i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SETTLE = 4'b0010,
        ST_RUN    = 4'b0100,
        ST_HOLD   = 4'b1000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic signed [COEF_W-1:0]   r_gain;
    logic [SUSED_W-1:0]         r_sused;
    t_tok                       r_tok0;
    t_tok                       n_tok0;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_val;
    logic                       r_out_sat;
    t_res                       r_pend;

    logic [NSEC_W-1:0]          n_eff;
    logic                       in_acc;
    logic                       out_free;
    logic                       load_res;
    logic                       load_pend;
    t_cw                        cw;
    t_tok                       c_in  [SECTIONS];
    t_tok                       c_out [SECTIONS];
    t_tok                       fin;
    t_res                       res;

    assign n_eff = (NSEC_W'(r_sused) > NSEC_W'(SECTIONS)) ? NSEC_W'(SECTIONS)
                                                          : NSEC_W'(r_sused);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = ~r_out_valid | ~i_out_stall;

    assign cw.vld = in_acc & i_mode;
    assign cw.idx = CIDX_W'(i_coef_index);
    assign cw.val = i_coef_value;

    always_comb begin
        n_tok0     = r_tok0;
        n_tok0.vld = 1'b0;
        if (in_acc && !i_mode) begin
            n_tok0.vld = 1'b1;
            n_tok0.sat = 1'b0;
            n_tok0.val = DATA_W'(i_sample_in);
        end
    end

    for (genvar s = 0; s < SECTIONS; s++) begin : g_sec
        if (s == 0) begin : g_first
            assign c_in[s] = r_tok0;
        end else begin : g_next
            assign c_in[s] = c_out[s-1];
        end
        cbq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (NSEC_W'(s) < n_eff),
            .i_base  (CIDX_W'(s * COEFS_PER_SECT)),
            .i_tok   (c_in[s]),
            .i_cw    (cw),
            .o_tok   (c_out[s])
        );
    end

    // Only one sample is in flight, so the last active section's output is picked by its valid flag.
    always_comb begin
        fin = '0;
        if (n_eff == '0) begin
            fin = r_tok0;
        end
        for (int s = 0; s < SECTIONS; s++) begin
            if (c_out[s].vld && (NSEC_W'(s + 1) == n_eff)) begin
                fin = c_out[s];
            end
        end
    end

    cbq_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (fin),
        .i_gain  (r_gain),
        .o_res   (res)
    );

    always_comb begin
        n_state   = r_state;
        load_res  = 1'b0;
        load_pend = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_mode ? ST_SETTLE : ST_RUN;
                end
            end
            ST_SETTLE: begin
                n_state = ST_IDLE;
            end
            ST_RUN: begin
                if (res.vld) begin
                    if (out_free) begin
                        load_res = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_pend = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid & i_out_stall) | load_res | load_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SETTLE;
            r_gain      <= GAIN_RESET;
            r_sused     <= SECTIONS_RESET;
            r_tok0.vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tok0      <= n_tok0;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_GAIN:     r_gain  <= $signed(i_cfg_data);
                    REG_SECTIONS: r_sused <= i_cfg_data[SUSED_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && res.vld) begin
            r_pend <= res;
        end
        if (load_res) begin
            r_out_val <= res.val;
            r_out_sat <= res.sat;
        end else if (load_pend) begin
            r_out_val <= r_pend.val;
            r_out_sat <= r_pend.sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_val;
    assign o_saturated  = r_out_sat;

endmodule

`default_nettype wire
